// ----- rtl/rational_arith_unit_assert.svh -----
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rau_pkg.sv -----
// Package with widths, operation codes and word types of the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

  // Operand field width and derived internal magnitude width.
  localparam int OperandWidth = 16;
  localparam int MagW         = 2 * OperandWidth;
  localparam int ReqTypeW     = 3;
  localparam int ResNumW      = 33;
  localparam int ResDenW      = 31;

  // Operation codes.
  typedef enum logic [ReqTypeW-1:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_EQ   = 3'd5
  } op_e;

  // Request word.
  typedef struct packed {
    logic [ReqTypeW-1:0]            req_type;
    logic signed [OperandWidth-1:0] lhs_num;
    logic signed [OperandWidth-1:0] lhs_den;
    logic signed [OperandWidth-1:0] rhs_num;
    logic signed [OperandWidth-1:0] rhs_den;
  } in_t;

  // Result word.
  typedef struct packed {
    logic signed [ResNumW-1:0] res_num;
    logic [ResDenW-1:0]        res_den;
    logic                      equal;
    logic                      error;
  } out_t;

endpackage

// ----- rtl/rational_arith_unit.sv -----
// Rational arithmetic unit: cross products, binary GCD reduction and exact division.
`timescale 1ns / 1ps
`include "rational_arith_unit_assert.svh"

// A request is taken when start_i is high and busy_o is low. Its result word
// appears on res_o with done_o high for exactly one cycle; the receiver cannot
// hold it off, so it must capture it in that cycle. Compare requests and unused
// operation codes finish without leaving idle (done_o follows the accepting edge).
// Normalize skips the products; add and subtract run three 16-step shift-add
// products, multiply and divide two, each after a setup state (S_LOAD). Reduction then
// runs a binary GCD loop, one halving or one subtract per cycle, whose length
// depends on the data, and two 32-step restoring divisions by the GCD. A zero
// numerator or zero denominator skips the reduction: done_o is then raised from
// S_CHECK, which follows the last product, or which directly follows acceptance
// in the normalize case.
module rational_arith_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rau_pkg::in_t  in_i,
  output logic          done_o,
  output rau_pkg::out_t res_o
);
  import rau_pkg::*;

  localparam int CntW = $clog2(MagW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD
  } state_e;

  typedef enum logic [1:0] {
    SLOT_TERM0,
    SLOT_TERM1,
    SLOT_DEN
  } slot_e;

  // Two's complement field to magnitude; the most negative value maps correctly.
  function automatic logic [OperandWidth-1:0] mag_of(input logic [OperandWidth-1:0] v);
    return v[OperandWidth-1] ? (~v + 1'b1) : v;
  endfunction

  state_e                  state_q;
  slot_e                   slot_q;
  op_e                     op_q;
  logic [CntW-1:0]         cnt_q;
  logic                    done_q;
  out_t                    res_q;

  // Operand magnitudes and signs.
  logic [OperandWidth-1:0] ln_mag_q, ld_mag_q, rn_mag_q, rd_mag_q;
  logic                    ln_neg_q, ld_neg_q, rn_neg_q, rd_neg_q;

  // Shift-add multiplier.
  logic [MagW-1:0]         mc_q;
  logic [OperandWidth-1:0] mp_q;
  logic [MagW-1:0]         acc_q;
  logic                    sgn_q;

  // Raw fraction, GCD pair and divider.
  logic [MagW-1:0]         num_q, den_q;
  logic                    num_neg_q, den_neg_q;
  logic [MagW-1:0]         u_q, v_q;
  logic [MagW-1:0]         rem_q, quo_q;

  // Combinational helpers.
  logic [OperandWidth-1:0] sel_x_mag, sel_y_mag;
  logic                    sel_x_neg, sel_y_neg;
  logic [MagW-1:0]         acc_nx;
  logic [MagW-1:0]         sadd_mag;
  logic                    sadd_neg;
  logic [MagW:0]           trial, tdiff;
  logic                    dge;
  logic [MagW-1:0]         rem_nx, quo_nx;
  logic [ResNumW-1:0]      num_pos, num_out;
  logic                    accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Operand pair for the product slot being set up.
  always_comb begin
    unique case (slot_q)
      SLOT_TERM0: begin
        sel_x_mag = ln_mag_q;
        sel_x_neg = ln_neg_q;
        sel_y_mag = (op_q == OP_MUL) ? rn_mag_q : rd_mag_q;
        sel_y_neg = (op_q == OP_MUL) ? rn_neg_q : rd_neg_q;
      end
      SLOT_TERM1: begin
        sel_x_mag = rn_mag_q;
        sel_x_neg = rn_neg_q;
        sel_y_mag = ld_mag_q;
        sel_y_neg = ld_neg_q;
      end
      default: begin
        sel_x_mag = ld_mag_q;
        sel_x_neg = ld_neg_q;
        sel_y_mag = (op_q == OP_DIV) ? rn_mag_q : rd_mag_q;
        sel_y_neg = (op_q == OP_DIV) ? rn_neg_q : rd_neg_q;
      end
    endcase
  end

  // One shift-add step.
  assign acc_nx = acc_q + (mp_q[0] ? mc_q : '0);

  // Sign-magnitude sum of the first term and the finished second product.
  always_comb begin
    if (num_neg_q == sgn_q) begin
      sadd_mag = num_q + acc_nx;
      sadd_neg = num_neg_q;
    end else if (num_q >= acc_nx) begin
      sadd_mag = num_q - acc_nx;
      sadd_neg = num_neg_q;
    end else begin
      sadd_mag = acc_nx - num_q;
      sadd_neg = sgn_q;
    end
  end

  // Restoring divider step, divisor is the GCD in u_q.
  assign trial  = {rem_q, quo_q[MagW-1]};
  assign dge    = (trial >= {1'b0, u_q});
  assign tdiff  = trial - {1'b0, u_q};
  assign rem_nx = dge ? tdiff[MagW-1:0] : trial[MagW-1:0];
  assign quo_nx = {quo_q[MagW-2:0], dge};

  // Signed result numerator from the reduced magnitude.
  assign num_pos = ResNumW'(num_q);
  assign num_out = num_neg_q ? (~num_pos + 1'b1) : num_pos;

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slot_q    <= SLOT_TERM0;
      op_q      <= OP_NORM;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      res_q     <= '0;
      ln_mag_q  <= '0;
      ld_mag_q  <= '0;
      rn_mag_q  <= '0;
      rd_mag_q  <= '0;
      ln_neg_q  <= 1'b0;
      ld_neg_q  <= 1'b0;
      rn_neg_q  <= 1'b0;
      rd_neg_q  <= 1'b0;
      mc_q      <= '0;
      mp_q      <= '0;
      acc_q     <= '0;
      sgn_q     <= 1'b0;
      num_q     <= '0;
      den_q     <= '0;
      num_neg_q <= 1'b0;
      den_neg_q <= 1'b0;
      u_q       <= '0;
      v_q       <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_e'(in_i.req_type);
            ln_mag_q <= mag_of(in_i.lhs_num);
            ld_mag_q <= mag_of(in_i.lhs_den);
            rn_mag_q <= mag_of(in_i.rhs_num);
            rd_mag_q <= mag_of(in_i.rhs_den);
            ln_neg_q <= in_i.lhs_num[OperandWidth-1];
            ld_neg_q <= in_i.lhs_den[OperandWidth-1];
            rn_neg_q <= in_i.rhs_num[OperandWidth-1];
            rd_neg_q <= in_i.rhs_den[OperandWidth-1];
            slot_q   <= SLOT_TERM0;
            case (op_e'(in_i.req_type))
              OP_NORM: begin
                num_q     <= MagW'(mag_of(in_i.lhs_num));
                den_q     <= MagW'(mag_of(in_i.lhs_den));
                num_neg_q <= in_i.lhs_num[OperandWidth-1];
                den_neg_q <= in_i.lhs_den[OperandWidth-1];
                state_q   <= S_CHECK;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                state_q <= S_LOAD;
              end
              OP_EQ: begin
                done_q        <= 1'b1;
                res_q.res_num <= '0;
                res_q.res_den <= ResDenW'(1);
                res_q.error   <= 1'b0;
                res_q.equal   <= (in_i.lhs_num == in_i.rhs_num) &&
                                 (in_i.lhs_den == in_i.rhs_den);
              end
              default: begin
                done_q        <= 1'b1;
                res_q.res_num <= '0;
                res_q.res_den <= ResDenW'(1);
                res_q.error   <= 1'b0;
                res_q.equal   <= 1'b0;
              end
            endcase
          end
        end

        // Set up the multiplier for the current slot.
        S_LOAD: begin
          mc_q    <= MagW'(sel_x_mag);
          mp_q    <= sel_y_mag;
          acc_q   <= '0;
          sgn_q   <= sel_x_neg ^ sel_y_neg ^ ((slot_q == SLOT_TERM1) && (op_q == OP_SUB));
          cnt_q   <= CntW'(OperandWidth - 1);
          state_q <= S_MUL;
        end

        // One multiplier bit per cycle; route the product when done.
        S_MUL: begin
          acc_q <= acc_nx;
          mc_q  <= mc_q << 1;
          mp_q  <= mp_q >> 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            case (slot_q)
              SLOT_TERM0: begin
                num_q     <= acc_nx;
                num_neg_q <= sgn_q;
                slot_q    <= (op_q == OP_ADD || op_q == OP_SUB) ? SLOT_TERM1 : SLOT_DEN;
                state_q   <= S_LOAD;
              end
              SLOT_TERM1: begin
                num_q     <= sadd_mag;
                num_neg_q <= sadd_neg;
                slot_q    <= SLOT_DEN;
                state_q   <= S_LOAD;
              end
              default: begin
                den_q     <= acc_nx;
                den_neg_q <= sgn_q;
                state_q   <= S_CHECK;
              end
            endcase
          end
        end

        // Zero numerator and zero denominator cases, else start the GCD.
        S_CHECK: begin
          if (num_q == '0 || den_q == '0) begin
            done_q        <= 1'b1;
            res_q.res_num <= '0;
            res_q.res_den <= ResDenW'(1);
            res_q.equal   <= 1'b0;
            res_q.error   <= (num_q != '0);
            state_q       <= S_IDLE;
          end else begin
            u_q       <= num_q;
            v_q       <= den_q;
            num_neg_q <= num_neg_q ^ den_neg_q;
            state_q   <= S_GCD;
          end
        end

        // Binary GCD; common factors of two are stripped from the fraction too.
        S_GCD: begin
          if (u_q == v_q) begin
            rem_q   <= '0;
            quo_q   <= num_q;
            cnt_q   <= CntW'(MagW - 1);
            state_q <= S_DIVN;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q   <= u_q >> 1;
            v_q   <= v_q >> 1;
            num_q <= num_q >> 1;
            den_q <= den_q >> 1;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q > v_q) begin
            u_q <= u_q - v_q;
          end else begin
            v_q <= v_q - u_q;
          end
        end

        // Numerator divided by the GCD, one quotient bit per cycle.
        S_DIVN: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            num_q   <= quo_nx;
            rem_q   <= '0;
            quo_q   <= den_q;
            cnt_q   <= CntW'(MagW - 1);
            state_q <= S_DIVD;
          end
        end

        // Denominator divided by the GCD, then the result word.
        S_DIVD: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            done_q        <= 1'b1;
            res_q.res_num <= num_out;
            res_q.res_den <= ResDenW'(quo_nx);
            res_q.equal   <= 1'b0;
            res_q.error   <= 1'b0;
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Checks.
  `RAU_ASSERT_IMPL(a_den_nonzero, clk_i, rst_ni, done_o, res_o.res_den != '0,
                   "result denominator is zero")
  `RAU_ASSERT_IMPL(a_error_result, clk_i, rst_ni, done_o && res_o.error,
                   res_o.res_num == '0 && res_o.res_den == ResDenW'(1) && !res_o.equal,
                   "error result is not 0/1")
  `RAU_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_o,
                   done_o || busy_o, "accepted request neither done nor in progress")
  `RAU_ASSERT_IMPL(a_gcd_nonzero, clk_i, rst_ni, state_q == S_GCD,
                   u_q != '0 && v_q != '0, "GCD operand reached zero")

endmodule
